/* src/sust_pkg.sv */
// Shared types and constants for the sorted unique set table.
package sust_pkg;

  // Field widths of the stream words
  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PositionW = 4;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned ElemCntW  = 5;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 16;

  // Request opcodes
  localparam logic [OpcodeW-1:0] OP_INSERT = 3'd0;
  localparam logic [OpcodeW-1:0] OP_ERASE  = 3'd1;
  localparam logic [OpcodeW-1:0] OP_FIND   = 3'd2;
  localparam logic [OpcodeW-1:0] OP_COUNT  = 3'd3;
  localparam logic [OpcodeW-1:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_DUP      = 3'd1;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatusW-1:0] ST_RANGE    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_ER_RD,
    S_ER_WR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_CNT,
    PTR_POS
  } ptr_op_e;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_RD_PTR,
    MEM_RD_PREV,
    MEM_RD_NEXT,
    MEM_WR_DATA,
    MEM_WR_VAL
  } mem_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  // Controller to datapath
  typedef struct packed {
    logic                capture;
    ptr_op_e             ptr_op;
    mem_op_e             mem_op;
    cnt_op_e             cnt_op;
    logic                at_load;
    logic                res_st_we;
    logic [StatusW-1:0]  res_status;
    logic                res_idx_we;
    logic                res_idx_pos;
    logic                res_match;
    logic                out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic               scan_end;
    logic               val_ge;
    logic               val_eq;
    logic               full;
    logic               pos_bad;
    logic               erase_last;
    logic               at_reached;
  } stat_t;

endpackage

/* src/sorted_unique_set_table.sv */
// Top level of the sorted unique set table: stream ports, controller and datapath.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         opcode[2:0], value[34:3], position[38:35], zero[39]
//  m_axis    out        status[2:0], found_index[6:3], match_count[7],
//                       element_count[12:8], zero[15:13]
//
// One request is in work at a time; the store is a single-port-write,
// registered-read RAM, so each examined or moved entry takes a read state
// and then a compare or write state. Find and count scan the entries;
// insert scans, then moves entries down from the tail and writes the value;
// erase moves later entries up over the erased one. Clear empties the count.
// Reset empties the set at once. A stalled result word holds in the output
// register while the next request is already taken and worked on.
module sorted_unique_set_table
  import sust_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // opcode, value, position
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // status, found_index, match_count, element_count
);

  cmd_t                cmd;
  stat_t               stat;
  logic [StatusW-1:0]  status;
  logic [IdxW-1:0]     found_index;
  logic                match_count;
  logic [ElemCntW-1:0] element_count;

  sust_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sust_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (s_axis_tdata[2:0]),
    .value_i         (s_axis_tdata[34:3]),
    .position_i      (s_axis_tdata[38:35]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status),
    .found_index_o   (found_index),
    .match_count_o   (match_count),
    .element_count_o (element_count)
  );

  // result word packing
  assign m_axis_tdata = {3'b000, element_count, match_count, found_index, status};

  // a taken request keeps the input closed while it is worked on
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input open right after a request was taken");

  // a new result word is posted only as the controller returns to idle
  a_post_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result posted while controller busy");

  // status codes stay within the defined set
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status <= ST_RANGE))
    else $error("undefined status code");

  // a match flag comes only with an ok status
  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && match_count) |-> (status == ST_OK))
    else $error("match flagged with error status");

endmodule

/* src/sust_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sust_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sust_dp.sv */
// Datapath: request registers, pointers, entry count, entry store and result word.
module sust_dp
  import sust_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [OpcodeW-1:0]   opcode_i,
  input  logic [ValueW-1:0]    value_i,
  input  logic [PositionW-1:0] position_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output logic [StatusW-1:0]   status_o,
  output logic [IdxW-1:0]      found_index_o,
  output logic                 match_count_o,
  output logic [ElemCntW-1:0]  element_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [OpcodeW-1:0]     opcode_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [PositionW-1:0]   pos_q;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          at_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [StatusW-1:0]     res_status_q;
  logic [CW-1:0]          res_idx_q;
  logic                   res_match_q;
  logic [StatusW-1:0]     out_status_q;
  logic [IdxW-1:0]        out_idx_q;
  logic                   out_match_q;
  logic [ElemCntW-1:0]    out_cnt_q;

  logic [VALUE_WIDTH+ValueW-1:0] val_wide;
  logic [CW+PositionW-1:0]       pos_wide;
  logic [CW+PositionW-1:0]       cnt_wide;
  logic [CW+IdxW-1:0]            idx_wide;
  logic [CW+ElemCntW-1:0]        ecnt_wide;
  logic [CW-1:0]                 pos_ptr;
  logic [CW-1:0]                 ptr_next;
  logic [CW-1:0]                 ptr_prev;

  logic                   ram_we;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // width adaption of the request fields
  assign val_wide  = {{VALUE_WIDTH{1'b0}}, value_i};
  assign pos_wide  = {{CW{1'b0}}, pos_q};
  assign cnt_wide  = {{PositionW{1'b0}}, cnt_q};
  assign pos_ptr   = pos_wide[CW-1:0];
  assign ptr_next  = ptr_q + CW'(1);
  assign ptr_prev  = ptr_q - CW'(1);

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      val_q    <= val_wide[VALUE_WIDTH-1:0];
      pos_q    <= position_i;
    end
    if (cmd_i.at_load) begin
      at_q <= ptr_q;
    end
  end

  // walking pointer
  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_next;
      PTR_DEC:  ptr_d = ptr_prev;
      PTR_CNT:  ptr_d = cnt_q;
      PTR_POS:  ptr_d = pos_ptr;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  // number of valid entries
  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // entry store access
  always_comb begin
    unique case (cmd_i.mem_op)
      MEM_RD_PREV: ram_raddr = ptr_prev[AW-1:0];
      MEM_RD_NEXT: ram_raddr = ptr_next[AW-1:0];
      default:     ram_raddr = ptr_q[AW-1:0];
    endcase
  end

  assign ram_re    = (cmd_i.mem_op == MEM_RD_PTR) || (cmd_i.mem_op == MEM_RD_PREV) ||
                     (cmd_i.mem_op == MEM_RD_NEXT);
  assign ram_we    = (cmd_i.mem_op == MEM_WR_DATA) || (cmd_i.mem_op == MEM_WR_VAL);
  assign ram_wdata = (cmd_i.mem_op == MEM_WR_VAL) ? val_q : ram_rdata;

  sust_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // status toward the controller
  assign stat_o.opcode     = opcode_q;
  assign stat_o.scan_end   = (ptr_q == cnt_q);
  assign stat_o.val_ge     = (val_q >= ram_rdata);
  assign stat_o.val_eq     = (val_q == ram_rdata);
  assign stat_o.full       = (cnt_q == CW'(DEPTH));
  assign stat_o.pos_bad    = (pos_wide >= cnt_wide);
  assign stat_o.erase_last = (ptr_next >= cnt_q);
  assign stat_o.at_reached = (ptr_q == at_q);

  // result collection, cleared when a request is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_status_q <= ST_OK;
      res_idx_q    <= '0;
      res_match_q  <= 1'b0;
    end else begin
      if (cmd_i.res_st_we) begin
        res_status_q <= cmd_i.res_status;
      end
      if (cmd_i.res_idx_we) begin
        res_idx_q <= cmd_i.res_idx_pos ? pos_ptr : ptr_q;
      end
      if (cmd_i.res_match) begin
        res_match_q <= 1'b1;
      end
    end
  end

  // output word register
  assign idx_wide  = {{IdxW{1'b0}}, res_idx_q};
  assign ecnt_wide = {{ElemCntW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= idx_wide[IdxW-1:0];
      out_match_q  <= res_match_q;
      out_cnt_q    <= ecnt_wide[ElemCntW-1:0];
    end
  end

  assign status_o        = out_status_q;
  assign found_index_o   = out_idx_q;
  assign match_count_o   = out_match_q;
  assign element_count_o = out_cnt_q;

endmodule

/* src/sust_ctrl.sv */
// Controller: sequences scan, shift and erase steps over the entry store.
module sust_ctrl
  import sust_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{capture: 1'b0, ptr_op: PTR_HOLD, mem_op: MEM_IDLE, cnt_op: CNT_HOLD,
                    at_load: 1'b0, res_st_we: 1'b0, res_status: ST_OK, res_idx_we: 1'b0,
                    res_idx_pos: 1'b0, res_match: 1'b0, out_load: 1'b0};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.ptr_op  = PTR_ZERO;
          state_d       = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (stat_i.opcode)
          OP_INSERT, OP_FIND, OP_COUNT: begin
            state_d = S_SCAN_RD;
          end
          OP_ERASE: begin
            if (stat_i.pos_bad) begin
              cmd_o.res_st_we  = 1'b1;
              cmd_o.res_status = ST_RANGE;
              state_d          = S_DONE;
            end else begin
              cmd_o.ptr_op      = PTR_POS;
              cmd_o.res_idx_we  = 1'b1;
              cmd_o.res_idx_pos = 1'b1;
              state_d           = S_ER_RD;
            end
          end
          OP_CLEAR: begin
            cmd_o.cnt_op = CNT_CLR;
            state_d      = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // walk entries until one is not larger than the value
      S_SCAN_RD: begin
        if (stat_i.scan_end) begin
          if (stat_i.opcode == OP_INSERT) begin
            state_d = S_INS_CHK;
          end else begin
            if (stat_i.opcode == OP_FIND) begin
              cmd_o.res_st_we  = 1'b1;
              cmd_o.res_status = ST_NOTFOUND;
            end
            state_d = S_DONE;
          end
        end else begin
          cmd_o.mem_op = MEM_RD_PTR;
          state_d      = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (stat_i.val_ge && stat_i.val_eq) begin
          // value present
          if (stat_i.opcode == OP_INSERT) begin
            cmd_o.res_st_we  = 1'b1;
            cmd_o.res_status = ST_DUP;
            cmd_o.res_idx_we = 1'b1;
          end else if (stat_i.opcode == OP_FIND) begin
            cmd_o.res_idx_we = 1'b1;
          end else begin
            cmd_o.res_match = 1'b1;
          end
          state_d = S_DONE;
        end else if (stat_i.val_ge) begin
          // passed the place where the value would sit
          if (stat_i.opcode == OP_INSERT) begin
            state_d = S_INS_CHK;
          end else begin
            if (stat_i.opcode == OP_FIND) begin
              cmd_o.res_st_we  = 1'b1;
              cmd_o.res_status = ST_NOTFOUND;
            end
            state_d = S_DONE;
          end
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_SCAN_RD;
        end
      end

      S_INS_CHK: begin
        if (stat_i.full) begin
          cmd_o.res_st_we  = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_DONE;
        end else begin
          cmd_o.at_load = 1'b1;
          cmd_o.ptr_op  = PTR_CNT;
          state_d       = S_SH_RD;
        end
      end

      // move smaller entries down from the tail, then drop the value in
      S_SH_RD: begin
        if (stat_i.at_reached) begin
          cmd_o.mem_op     = MEM_WR_VAL;
          cmd_o.res_idx_we = 1'b1;
          cmd_o.cnt_op     = CNT_INC;
          state_d          = S_DONE;
        end else begin
          cmd_o.mem_op = MEM_RD_PREV;
          state_d      = S_SH_WR;
        end
      end

      S_SH_WR: begin
        cmd_o.mem_op = MEM_WR_DATA;
        cmd_o.ptr_op = PTR_DEC;
        state_d      = S_SH_RD;
      end

      // move later entries up over the erased one
      S_ER_RD: begin
        if (stat_i.erase_last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.mem_op = MEM_RD_NEXT;
          state_d      = S_ER_WR;
        end
      end

      S_ER_WR: begin
        cmd_o.mem_op = MEM_WR_DATA;
        cmd_o.ptr_op = PTR_INC;
        state_d      = S_ER_RD;
      end

      // post the result word once the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
